### sv/tty_echo_tx_queue_engine_macros.svh
// assertion macros shared by the queue engine rtl
// depends on a clk and an active-low rst_n in the including module
`ifndef TTY_ECHO_TX_QUEUE_ENGINE_MACROS_SVH
`define TTY_ECHO_TX_QUEUE_ENGINE_MACROS_SVH

// same-cycle implication, checked outside reset
`define TTEQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define TTEQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/tteq_pkg.sv
// types and constants for the tty echo / transmit queue engine
// no dependencies; used by every module of the block
package tteq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_RX_CHAR  = 2'd0,
    CMD_TX_READY = 2'd1,
    CMD_WRITE    = 2'd2,
    CMD_READ     = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_irq_enabled;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       write_accepted;
    logic       rx_dropped;
  } out_word_t;

  // per-cell control from the queue to one byte cell
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

### sv/tteq_cell.sv
// one byte cell of a shifting queue
// depends on tteq_pkg
module tteq_cell (
  input  logic                clk,
  input  tteq_pkg::cell_ctl_t ctl,
  input  logic [7:0]          load_data,
  input  logic [7:0]          shift_in,
  output logic [7:0]          data
);

  logic [7:0] data_r;
  logic [7:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.load) begin
      data_nxt = load_data;
    end else if (ctl.shift) begin
      data_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

### sv/tteq_fifo.sv
// byte queue built as a row of cells, head in cell 0, shifting on pop
// depends on tteq_pkg, tteq_cell and the assertion macro header
`include "tty_echo_tx_queue_engine_macros.svh"

module tteq_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic                       pop,
  input  logic [7:0]                 din,
  output logic [7:0]                 head,
  output logic [tteq_pkg::CNT_W-1:0] count,
  output logic                       full,
  output logic                       empty
);

  localparam int D = tteq_pkg::QUEUE_DEPTH;
  localparam int W = tteq_pkg::CNT_W;

  logic [W-1:0]        count_r;
  logic [W-1:0]        count_nxt;
  logic [W-1:0]        load_idx;
  logic                push_ok;
  logic                pop_ok;
  logic [7:0]          cell_q [D];
  tteq_pkg::cell_ctl_t ctl [D];

  assign full    = (count_r == W'(D));
  assign empty   = (count_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;

  // new byte lands just past the last live entry, one lower when shifting
  assign load_idx = pop_ok ? (count_r - W'(1)) : count_r;

  always_comb begin
    count_nxt = count_r;
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + W'(1);
    end else if (pop_ok && !push_ok) begin
      count_nxt = count_r - W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  for (genvar i = 0; i < D; i++) begin : g_cell
    logic [7:0] nbr;
    if (i == D - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end
    assign ctl[i].load  = push_ok && (load_idx == W'(i));
    assign ctl[i].shift = pop_ok;
    tteq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl[i]),
      .load_data (din),
      .shift_in  (nbr),
      .data      (cell_q[i])
    );
  end

  assign head  = cell_q[0];
  assign count = count_r;

  `TTEQ_ASSERT_IMP(a_count_range, 1'b1, count_r <= W'(D), "queue count beyond depth")
  `TTEQ_ASSERT_NXT(a_pop_dec, pop_ok && !push_ok, count_r == $past(count_r) - W'(1), "pop miscount")
  `TTEQ_ASSERT_NXT(a_pop_shift, pop_ok && !push_ok && (count_r > W'(1)), cell_q[0] == $past(cell_q[1]), "head not shifted")

endmodule

### sv/tty_echo_tx_queue_engine.sv
// tty echo / transmit queue engine: receive, echo and transmit byte queues
// the result word strobes on out_valid the cycle after start
// throughput: one event word per cycle, busy is never raised
// each queue is a row of byte cells: a push loads past the tail, a pop shifts toward the head
// reset: queues empty, transmit interrupt flag off, echo enabled
// the receiver cannot stall: every result word is shown for exactly one cycle
`include "tty_echo_tx_queue_engine_macros.svh"

module tty_echo_tx_queue_engine (
  input  logic                clk,
  input  logic                rst_n,
  // event word
  input  logic                start,
  output logic                busy,
  input  tteq_pkg::in_word_t  in_data,
  // result word
  output logic                out_valid,
  output tteq_pkg::out_word_t out_data,
  // echo enable register
  input  logic                cfg_we,
  input  logic                cfg_wdata
);

  localparam int W = tteq_pkg::CNT_W;
  localparam int D = tteq_pkg::QUEUE_DEPTH;

  logic                accept;
  logic                echo_en_r;
  logic                irq_r;
  logic                irq_nxt;
  logic                out_valid_r;
  tteq_pkg::out_word_t out_r;
  tteq_pkg::out_word_t out_nxt;

  // queue hookup
  logic         rx_push,   rx_pop,   rx_full,   rx_empty;
  logic         echo_push, echo_pop, echo_full, echo_empty;
  logic         tx_push,   tx_pop,   tx_full,   tx_empty;
  logic [7:0]   rx_head,   echo_head, tx_head;
  logic [W-1:0] rx_count,  echo_count, tx_count;

  // event kinds seen by the checks below
  logic         rd_other;
  logic         wr_empty;

  // each event is decoded as it is accepted, so never busy
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign rd_other = accept && (in_data.cmd != tteq_pkg::CMD_READ);
  assign wr_empty = accept && (in_data.cmd == tteq_pkg::CMD_WRITE) && (tx_count == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_en_r <= 1'b1;
    end else if (cfg_we) begin
      echo_en_r <= cfg_wdata;
    end
  end

  // event decode: pushes and pops, result word and next interrupt flag
  always_comb begin
    rx_push   = 1'b0;
    rx_pop    = 1'b0;
    echo_push = 1'b0;
    echo_pop  = 1'b0;
    tx_push   = 1'b0;
    tx_pop    = 1'b0;
    irq_nxt   = irq_r;
    out_nxt   = '0;
    if (accept) begin
      case (in_data.cmd)
        tteq_pkg::CMD_RX_CHAR: begin
          rx_push            = 1'b1;
          out_nxt.rx_dropped = rx_full;
          if (echo_en_r) begin
            echo_push = 1'b1;
            // echo queue holds exactly one byte afterwards only if it was empty
            if (echo_empty) begin
              irq_nxt = 1'b1;
            end
          end
        end
        tteq_pkg::CMD_TX_READY: begin
          // echo traffic goes ahead of software writes
          if (!echo_empty) begin
            echo_pop         = 1'b1;
            out_nxt.tx_valid = 1'b1;
            out_nxt.tx_byte  = echo_head;
          end else if (!tx_empty) begin
            tx_pop           = 1'b1;
            out_nxt.tx_valid = 1'b1;
            out_nxt.tx_byte  = tx_head;
            irq_nxt          = 1'b1;
          end else begin
            irq_nxt = 1'b0;
          end
        end
        tteq_pkg::CMD_WRITE: begin
          tx_push                = 1'b1;
          out_nxt.write_accepted = !tx_full;
          irq_nxt                = 1'b1;
        end
        tteq_pkg::CMD_READ: begin
          if (!rx_empty) begin
            rx_pop             = 1'b1;
            out_nxt.read_valid = 1'b1;
            out_nxt.read_byte  = rx_head;
          end
        end
        default: begin
          out_nxt = '0;
        end
      endcase
    end
    out_nxt.tx_irq_enabled = irq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      irq_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      irq_r       <= irq_nxt;
      out_valid_r <= accept;
    end
  end

  // result payload, qualified by out_valid
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  tteq_fifo u_rx_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rx_push),
    .pop   (rx_pop),
    .din   (in_data.data_byte),
    .head  (rx_head),
    .count (rx_count),
    .full  (rx_full),
    .empty (rx_empty)
  );

  tteq_fifo u_echo_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (echo_push),
    .pop   (echo_pop),
    .din   (in_data.data_byte),
    .head  (echo_head),
    .count (echo_count),
    .full  (echo_full),
    .empty (echo_empty)
  );

  tteq_fifo u_tx_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (tx_push),
    .pop   (tx_pop),
    .din   (in_data.data_byte),
    .head  (tx_head),
    .count (tx_count),
    .full  (tx_full),
    .empty (tx_empty)
  );

  // echo byte always drains before a software-written byte
  `TTEQ_ASSERT_IMP(a_echo_first, tx_pop, echo_count == '0, "tx queue popped ahead of echo")
  // a read word only comes back from a read event that found data
  `TTEQ_ASSERT_NXT(a_read_src, rd_other, !out_data.read_valid, "stray read word")
  // the reported interrupt enable matches the flag that was stored
  `TTEQ_ASSERT_IMP(a_irq_match, out_valid, out_data.tx_irq_enabled == irq_r, "irq report mismatch")
  // a write to an empty tx queue is accepted and leaves it holding one byte
  `TTEQ_ASSERT_NXT(a_wr_count, wr_empty, tx_count == W'(1) && out_data.write_accepted, "write lost")
  // rx and echo full flags agree with the counts
  `TTEQ_ASSERT_IMP(a_rx_full, rx_full, rx_count == W'(D), "rx full flag off count")
  `TTEQ_ASSERT_IMP(a_echo_full, echo_full, echo_count == W'(D), "echo full flag off count")

endmodule
